/* rtl/core/sts_pkg.sv */
// Shared types, character codes and helpers for the script token splitter.
`timescale 1ns / 1ps
package sts_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_WS_MAX = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CHAR_APOS   = 8'h27;
  localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CHAR_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_WORD    = 3'd4
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOT  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] token_char;
  } res_t;

  // Results caused by one input byte, in emit order
  typedef struct packed {
    logic [2:0]             cnt;
    res_t [MAX_RES-1:0]     res;
  } bundle_t;

  function automatic logic is_break(logic [CHAR_W-1:0] c, logic ignore_colons);
    logic brk;
    brk = (c == CHAR_LBRACE) || (c == CHAR_RBRACE) || (c == CHAR_LPAREN) ||
          (c == CHAR_RPAREN) || (c == CHAR_APOS);
    return brk || ((c == CHAR_COLON) && !ignore_colons);
  endfunction

endpackage

/* rtl/core/sts_intf.sv */
// Handshake channel interfaces for text bytes, results and configuration.
`timescale 1ns / 1ps
interface sts_in_if;
  logic                       valid;
  logic                       ready;
  logic [sts_pkg::CHAR_W-1:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface sts_out_if;
  logic                       valid;
  logic                       ready;
  logic [sts_pkg::KIND_W-1:0] kind;
  logic [sts_pkg::CHAR_W-1:0] token_char;
  logic                       last_of_run;
  modport source (output valid, output kind, output token_char, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input token_char, input last_of_run,
                output ready);
endinterface

interface sts_cfg_if;
  logic valid;
  logic ready;
  logic ignore_colons;
  modport source (output valid, output ignore_colons, input ready);
  modport sink (input valid, input ignore_colons, output ready);
endinterface

/* rtl/core/sts_front.sv */
// Front end: accepts text bytes, tracks the parse mode and builds result bundles.
`timescale 1ns / 1ps
module sts_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  sts_in_if.sink           in_ch_i,
  sts_cfg_if.sink          cfg_i,
  input  logic             full_i,
  output logic             push_o,
  output sts_pkg::bundle_t bundle_o
);
  import sts_pkg::*;

  mode_e             mode_q, mode_d;
  logic              ign_q;
  logic              accept;
  logic              brk;
  logic [CHAR_W-1:0] c;
  bundle_t           bun;

  // Append one result to a bundle
  function automatic bundle_t put(bundle_t b, kind_e k, logic [CHAR_W-1:0] ch);
    bundle_t r;
    r = b;
    r.res[b.cnt[1:0]].kind = k;
    r.res[b.cnt[1:0]].token_char = (k == KIND_CHAR) ? ch : '0;
    r.cnt = b.cnt + 3'd1;
    return r;
  endfunction

  // Results for a byte that follows at least one emitted word character
  function automatic bundle_t word_res(bundle_t b, logic [CHAR_W-1:0] ch, logic bk);
    bundle_t r;
    r = b;
    if (bk) begin
      r = put(r, KIND_END, '0);
      r = put(r, KIND_CHAR, ch);
      r = put(r, KIND_END, '0);
    end else if (ch <= CHAR_WS_MAX) begin
      r = put(r, KIND_END, '0);
      if (ch == CHAR_NUL) begin
        r = put(r, KIND_EOT, '0);
      end
    end else begin
      r = put(r, KIND_CHAR, ch);
    end
    return r;
  endfunction

  assign c = in_ch_i.ch;
  assign brk = is_break(c, ign_q);
  assign in_ch_i.ready = !full_i;
  assign accept = in_ch_i.valid && in_ch_i.ready;
  assign cfg_i.ready = 1'b1;

  // Classify the byte against the current mode
  always_comb begin
    bun = '0;
    mode_d = mode_q;
    case (mode_q)
      MODE_SLASH: begin
        if (c == CHAR_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          bun = put(bun, KIND_CHAR, CHAR_SLASH);
          bun = word_res(bun, c, brk);
          mode_d = (brk || (c <= CHAR_WS_MAX)) ? MODE_IDLE : MODE_WORD;
        end
      end
      MODE_COMMENT: begin
        if (c == CHAR_NUL) begin
          bun = put(bun, KIND_EOT, '0);
          mode_d = MODE_IDLE;
        end else if (c == CHAR_NL) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (c == CHAR_QUOTE) begin
          bun = put(bun, KIND_END, '0);
          mode_d = MODE_IDLE;
        end else if (c == CHAR_NUL) begin
          bun = put(bun, KIND_END, '0);
          bun = put(bun, KIND_EOT, '0);
          mode_d = MODE_IDLE;
        end else begin
          bun = put(bun, KIND_CHAR, c);
        end
      end
      MODE_WORD: begin
        bun = word_res(bun, c, brk);
        mode_d = (brk || (c <= CHAR_WS_MAX)) ? MODE_IDLE : MODE_WORD;
      end
      default: begin
        if (c == CHAR_NUL) begin
          bun = put(bun, KIND_EOT, '0);
          mode_d = MODE_IDLE;
        end else if (c <= CHAR_WS_MAX) begin
          mode_d = MODE_IDLE;
        end else if (c == CHAR_SLASH) begin
          mode_d = MODE_SLASH;
        end else if (c == CHAR_QUOTE) begin
          mode_d = MODE_STRING;
        end else if (brk) begin
          bun = put(bun, KIND_CHAR, c);
          bun = put(bun, KIND_END, '0);
          mode_d = MODE_IDLE;
        end else begin
          bun = put(bun, KIND_CHAR, c);
          mode_d = MODE_WORD;
        end
      end
    endcase
  end

  assign push_o = accept && (bun.cnt != 3'd0);
  assign bundle_o = bun;

  // Advance the mode on every accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  // Hold the colon setting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      ign_q <= cfg_i.ignore_colons;
    end
  end

endmodule

/* rtl/core/sts_queue.sv */
// Short bundle queue between the front end and the result serializer.
`timescale 1ns / 1ps
module sts_queue #(
  parameter int unsigned Depth = sts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sts_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output sts_pkg::bundle_t pop_data_o
);
  import sts_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o = (cnt_q == CntFull);
  assign avail_o = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && avail_o;

  // Write the incoming bundle
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull) else $error("queue fill count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("bundle pushed into full queue");

  a_nonempty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (push_data_i.cnt != 3'd0)) else $error("empty bundle queued");

endmodule

/* rtl/core/sts_back.sv */
// Back end: holds one bundle and sends its results one item per cycle while res_o.ready is high.
`timescale 1ns / 1ps
module sts_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  sts_pkg::bundle_t bundle_i,
  output logic             pop_o,
  sts_out_if.source        res_o
);
  import sts_pkg::*;

  bundle_t    bun_q, bun_d;
  logic [1:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       fire, last;

  assign last = ({1'b0, idx_q} + 3'd1) == bun_q.cnt;
  assign fire = res_o.valid && res_o.ready;

  // Drive the current result straight from the held bundle
  assign res_o.valid = busy_q;
  assign res_o.kind = bun_q.res[idx_q].kind;
  assign res_o.token_char = bun_q.res[idx_q].token_char;
  assign res_o.last_of_run = last;

  // Step through the bundle; load the next one as the last result leaves
  always_comb begin
    pop_o = 1'b0;
    bun_d = bun_q;
    idx_d = idx_q;
    busy_d = busy_q;
    if (!busy_q || (fire && last)) begin
      pop_o = avail_i;
      busy_d = avail_i;
      bun_d = bundle_i;
      idx_d = '0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bun_q <= bun_d;
  end

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ({1'b0, idx_q} < bun_q.cnt)) else $error("result index past bundle");

  a_mark_zero_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (res_o.kind != KIND_CHAR)) |-> (res_o.token_char == '0))
    else $error("token end or end of text carries a character");

endmodule

/* rtl/core/script_token_splitter.sv */
// Top level of the script token splitter: front end, bundle queue, serializer.
// A byte's results pass through the bundle queue and the serializer's bundle register to res_o.
// Throughput: one byte per cycle unless the queue is full; output one result per cycle
//   while res_o is ready, up to four per byte, so the serializer's drain sets input rate.
// The queue holds QueueDepth bundles; input ready drops only when it is full.
// Reset (rst_ni low, asynchronous) empties the queue, returns the mode to idle
//   and clears the colon setting.
`timescale 1ns / 1ps
module script_token_splitter #(
  parameter int unsigned QueueDepth = sts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  sts_in_if.sink     in_ch_i,
  sts_cfg_if.sink    cfg_i,
  sts_out_if.source  res_o
);
  import sts_pkg::*;

  logic    push, full, pop, avail;
  bundle_t push_data, pop_data;

  sts_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch_i),
    .cfg_i    (cfg_i),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (push_data)
  );

  sts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .avail_o     (avail),
    .pop_data_o  (pop_data)
  );

  sts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (avail),
    .bundle_i (pop_data),
    .pop_o    (pop),
    .res_o    (res_o)
  );

endmodule
